FILE: rtl/tmi_pkg.sv
// tmi_pkg: shared types and constants for the tape machine interpreter.
// Holds the word structs, the datapath action codes and the datapath flags seen by the sequencer.
// No dependencies.
package tmi_pkg;

  // Sizes
  localparam int TAPE_CELLS = 32768;
  localparam int PROG_DEPTH = 4096;
  localparam int CELL_W     = 32;

  localparam int TAPE_AW = $clog2(TAPE_CELLS);
  localparam int PROG_AW = $clog2(PROG_DEPTH);
  localparam int PC_W    = PROG_AW + 1;   // holds 0 .. PROG_DEPTH
  localparam int DP_W    = TAPE_AW;

  // Instruction bytes
  localparam logic [7:0] OP_RIGHT = 8'h3E;  // >
  localparam logic [7:0] OP_LEFT  = 8'h3C;  // <
  localparam logic [7:0] OP_PLUS  = 8'h2B;  // +
  localparam logic [7:0] OP_MINUS = 8'h2D;  // -
  localparam logic [7:0] OP_PUT   = 8'h2E;  // .
  localparam logic [7:0] OP_GET   = 8'h2C;  // ,
  localparam logic [7:0] OP_OPEN  = 8'h5B;  // [
  localparam logic [7:0] OP_CLOSE = 8'h5D;  // ]

  // Command field values
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_PTR     = 2'd1,
    ERR_BRACKET = 2'd2
  } err_e;

  typedef struct packed {
    logic              command;
    logic [7:0]        program_byte;
    logic              last_byte;
    logic signed [7:0] input_char;
  } tmi_in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_char;
    logic       input_used;
    logic       halted;
    logic [1:0] error_code;
  } tmi_out_t;

  // Datapath actions, one per control word
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_LOAD,
    ACT_RD_OP,
    ACT_DP_INC,
    ACT_DP_DEC,
    ACT_CELL_INC,
    ACT_CELL_DEC,
    ACT_PUT_CHAR,
    ACT_GET_CHAR,
    ACT_SCAN_FWD,
    ACT_SCAN_BWD,
    ACT_SCAN_STEP,
    ACT_SCAN_DEPTH,
    ACT_PC_MATCH,
    ACT_PC_INC,
    ACT_SET_HALT,
    ACT_ERR_PTR,
    ACT_ERR_BR,
    ACT_EMIT
  } act_e;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic       clr_busy;
    logic       halted;
    logic       pc_end;
    logic       dp_last;
    logic       dp_first;
    logic       cell_zero;
    logic       scan_end;
    logic       no_match;
    logic [7:0] opcode;
  } tmi_stat_t;

endpackage

FILE: rtl/tmi_seq.sv
// tmi_seq: microcode sequencer. Micro-PC, control store, opcode dispatch.
// Depends on tmi_pkg.
module tmi_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  input  logic               out_busy_i,
  input  tmi_pkg::tmi_stat_t stat_i,
  output logic               ready_o,
  output tmi_pkg::act_e      act_o
);

  typedef enum logic [1:0] {
    W_NONE,
    W_ACCEPT,
    W_OUT
  } wait_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_STEP,
    C_HALTED,
    C_PC_END,
    C_PC_LT_END,
    C_DISPATCH,
    C_DP_LAST,
    C_DP_FIRST,
    C_CELL_NZ,
    C_CELL_Z,
    C_SCAN_END,
    C_NO_MATCH
  } cond_e;

  typedef struct packed {
    tmi_pkg::act_e act;
    wait_e         wt;
    cond_e         cond;
    logic [4:0]    target;
  } uword_t;

  // micro addresses
  localparam logic [4:0] U_IDLE     = 5'd0;
  localparam logic [4:0] U_LOAD     = 5'd1;
  localparam logic [4:0] U_CHK      = 5'd2;
  localparam logic [4:0] U_RD       = 5'd3;
  localparam logic [4:0] U_DISP     = 5'd4;
  localparam logic [4:0] U_RIGHT    = 5'd5;
  localparam logic [4:0] U_RIGHT_GO = 5'd6;
  localparam logic [4:0] U_LEFT     = 5'd7;
  localparam logic [4:0] U_LEFT_GO  = 5'd8;
  localparam logic [4:0] U_PLUS     = 5'd9;
  localparam logic [4:0] U_MINUS    = 5'd10;
  localparam logic [4:0] U_PUT      = 5'd11;
  localparam logic [4:0] U_GET      = 5'd12;
  localparam logic [4:0] U_OPEN     = 5'd13;
  localparam logic [4:0] U_OPEN_GO  = 5'd14;
  localparam logic [4:0] U_CLOSE    = 5'd15;
  localparam logic [4:0] U_CLOSE_GO = 5'd16;
  localparam logic [4:0] U_SCAN     = 5'd17;
  localparam logic [4:0] U_SCAN_CHK = 5'd18;
  localparam logic [4:0] U_FOUND    = 5'd19;
  localparam logic [4:0] U_ADV      = 5'd20;
  localparam logic [4:0] U_PCCHK    = 5'd21;
  localparam logic [4:0] U_HALT     = 5'd22;
  localparam logic [4:0] U_ERR_PTR  = 5'd23;
  localparam logic [4:0] U_ERR_BR   = 5'd24;
  localparam logic [4:0] U_EMIT     = 5'd25;

  function automatic uword_t uw(tmi_pkg::act_e a, wait_e w, cond_e c, logic [4:0] t);
    uword_t r;
    r.act    = a;
    r.wt     = w;
    r.cond   = c;
    r.target = t;
    return r;
  endfunction

  // control store
  function automatic uword_t ucode(logic [4:0] addr);
    uword_t r;
    unique case (addr)
      U_IDLE:     r = uw(tmi_pkg::ACT_LATCH,      W_ACCEPT, C_IN_STEP,   U_CHK);
      U_LOAD:     r = uw(tmi_pkg::ACT_LOAD,       W_NONE,   C_ALWAYS,    U_EMIT);
      U_CHK:      r = uw(tmi_pkg::ACT_NONE,       W_NONE,   C_HALTED,    U_EMIT);
      U_RD:       r = uw(tmi_pkg::ACT_RD_OP,      W_NONE,   C_PC_END,    U_HALT);
      U_DISP:     r = uw(tmi_pkg::ACT_NONE,       W_NONE,   C_DISPATCH,  U_ADV);
      U_RIGHT:    r = uw(tmi_pkg::ACT_NONE,       W_NONE,   C_DP_LAST,   U_ERR_PTR);
      U_RIGHT_GO: r = uw(tmi_pkg::ACT_DP_INC,     W_NONE,   C_ALWAYS,    U_ADV);
      U_LEFT:     r = uw(tmi_pkg::ACT_NONE,       W_NONE,   C_DP_FIRST,  U_ERR_PTR);
      U_LEFT_GO:  r = uw(tmi_pkg::ACT_DP_DEC,     W_NONE,   C_ALWAYS,    U_ADV);
      U_PLUS:     r = uw(tmi_pkg::ACT_CELL_INC,   W_NONE,   C_ALWAYS,    U_ADV);
      U_MINUS:    r = uw(tmi_pkg::ACT_CELL_DEC,   W_NONE,   C_ALWAYS,    U_ADV);
      U_PUT:      r = uw(tmi_pkg::ACT_PUT_CHAR,   W_NONE,   C_ALWAYS,    U_ADV);
      U_GET:      r = uw(tmi_pkg::ACT_GET_CHAR,   W_NONE,   C_ALWAYS,    U_ADV);
      U_OPEN:     r = uw(tmi_pkg::ACT_NONE,       W_NONE,   C_CELL_NZ,   U_ADV);
      U_OPEN_GO:  r = uw(tmi_pkg::ACT_SCAN_FWD,   W_NONE,   C_ALWAYS,    U_SCAN);
      U_CLOSE:    r = uw(tmi_pkg::ACT_NONE,       W_NONE,   C_CELL_Z,    U_ADV);
      U_CLOSE_GO: r = uw(tmi_pkg::ACT_SCAN_BWD,   W_NONE,   C_NEVER,     U_SCAN);
      U_SCAN:     r = uw(tmi_pkg::ACT_SCAN_STEP,  W_NONE,   C_SCAN_END,  U_ERR_BR);
      U_SCAN_CHK: r = uw(tmi_pkg::ACT_SCAN_DEPTH, W_NONE,   C_NO_MATCH,  U_SCAN);
      U_FOUND:    r = uw(tmi_pkg::ACT_PC_MATCH,   W_NONE,   C_ALWAYS,    U_PCCHK);
      U_ADV:      r = uw(tmi_pkg::ACT_PC_INC,     W_NONE,   C_NEVER,     U_PCCHK);
      U_PCCHK:    r = uw(tmi_pkg::ACT_NONE,       W_NONE,   C_PC_LT_END, U_EMIT);
      U_HALT:     r = uw(tmi_pkg::ACT_SET_HALT,   W_NONE,   C_ALWAYS,    U_EMIT);
      U_ERR_PTR:  r = uw(tmi_pkg::ACT_ERR_PTR,    W_NONE,   C_ALWAYS,    U_EMIT);
      U_ERR_BR:   r = uw(tmi_pkg::ACT_ERR_BR,     W_NONE,   C_NEVER,     U_EMIT);
      U_EMIT:     r = uw(tmi_pkg::ACT_EMIT,       W_OUT,    C_ALWAYS,    U_IDLE);
      default:    r = uw(tmi_pkg::ACT_NONE,       W_NONE,   C_ALWAYS,    U_IDLE);
    endcase
    return r;
  endfunction

  // opcode -> routine; anything else just advances pc
  function automatic logic [4:0] dispatch(logic [7:0] op);
    logic [4:0] r;
    unique case (op)
      tmi_pkg::OP_RIGHT: r = U_RIGHT;
      tmi_pkg::OP_LEFT:  r = U_LEFT;
      tmi_pkg::OP_PLUS:  r = U_PLUS;
      tmi_pkg::OP_MINUS: r = U_MINUS;
      tmi_pkg::OP_PUT:   r = U_PUT;
      tmi_pkg::OP_GET:   r = U_GET;
      tmi_pkg::OP_OPEN:  r = U_OPEN;
      tmi_pkg::OP_CLOSE: r = U_CLOSE;
      default:           r = U_ADV;
    endcase
    return r;
  endfunction

  logic [4:0] upc_q, upc_d;
  uword_t     uword;
  logic       accept;
  logic       stall;
  logic       taken;

  assign uword   = ucode(upc_q);
  assign ready_o = (upc_q == U_IDLE) && !stat_i.clr_busy;
  assign accept  = in_valid_i && ready_o;

  always_comb begin
    unique case (uword.wt)
      W_ACCEPT: stall = !accept;
      W_OUT:    stall = out_busy_i;
      default:  stall = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uword.cond)
      C_ALWAYS:    taken = 1'b1;
      C_IN_STEP:   taken = (in_cmd_i == tmi_pkg::CMD_STEP);
      C_HALTED:    taken = stat_i.halted;
      C_PC_END:    taken = stat_i.pc_end;
      C_PC_LT_END: taken = !stat_i.pc_end;
      C_DP_LAST:   taken = stat_i.dp_last;
      C_DP_FIRST:  taken = stat_i.dp_first;
      C_CELL_NZ:   taken = !stat_i.cell_zero;
      C_CELL_Z:    taken = stat_i.cell_zero;
      C_SCAN_END:  taken = stat_i.scan_end;
      C_NO_MATCH:  taken = stat_i.no_match;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    priority if (stall) begin
      upc_d = upc_q;
    end else if (uword.cond == C_DISPATCH) begin
      upc_d = dispatch(stat_i.opcode);
    end else if (taken) begin
      upc_d = uword.target;
    end else begin
      upc_d = upc_q + 5'd1;
    end
  end

  assign act_o = stall ? tmi_pkg::ACT_NONE : uword.act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

FILE: rtl/tmi_datapath.sv
// tmi_datapath: machine registers, program store, tape memory and its clear sweep.
// Driven one action per cycle by tmi_seq. Depends on tmi_pkg.
module tmi_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tmi_pkg::tmi_in_t   in_i,
  input  tmi_pkg::act_e      act_i,
  output tmi_pkg::tmi_stat_t stat_o,
  output tmi_pkg::tmi_out_t  res_o
);

  localparam int PC_W   = tmi_pkg::PC_W;
  localparam int DP_W   = tmi_pkg::DP_W;
  localparam int CELL_W = tmi_pkg::CELL_W;
  localparam int PA_W   = tmi_pkg::PROG_AW;

  logic [7:0]        prog_mem [tmi_pkg::PROG_DEPTH];
  logic [CELL_W-1:0] tape_mem [tmi_pkg::TAPE_CELLS];

  tmi_pkg::tmi_in_t  in_q;
  logic [PC_W-1:0]   len_q, len_d;
  logic [PC_W-1:0]   lp_q, lp_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [DP_W-1:0]   dp_q, dp_d;
  logic              halt_q, halt_d;
  tmi_pkg::err_e     err_q, err_d;
  logic [PC_W-1:0]   scan_q, scan_d;
  logic [PC_W-1:0]   depth_q, depth_d;
  logic              fwd_q, fwd_d;
  logic              rv_q, rv_d;
  logic [7:0]        rc_q, rc_d;
  logic              ru_q, ru_d;
  logic              clr_busy_q;
  logic [DP_W-1:0]   clr_addr_q;

  logic [7:0]        prog_rd_q;
  logic [CELL_W-1:0] cell_q;

  logic              lp_room;
  logic [PC_W-1:0]   lp_next;
  logic [PC_W-1:0]   scan_nxt;
  logic [PC_W-1:0]   depth_new;
  logic              prog_we, prog_re;
  logic [PA_W-1:0]   prog_raddr;
  logic              tape_we, tape_re;
  logic [DP_W-1:0]   tape_waddr;
  logic [CELL_W-1:0] tape_wdata, cell_new;

  assign lp_room  = (lp_q < PC_W'(tmi_pkg::PROG_DEPTH));
  assign lp_next  = lp_room ? lp_q + PC_W'(1) : lp_q;
  assign scan_nxt = fwd_q ? scan_q + PC_W'(1) : scan_q - PC_W'(1);

  // bracket nesting after the byte just read
  always_comb begin
    depth_new = depth_q;
    if (prog_rd_q == tmi_pkg::OP_OPEN) begin
      depth_new = fwd_q ? depth_q + PC_W'(1) : depth_q - PC_W'(1);
    end else if (prog_rd_q == tmi_pkg::OP_CLOSE) begin
      depth_new = fwd_q ? depth_q - PC_W'(1) : depth_q + PC_W'(1);
    end
  end

  always_comb begin
    unique case (act_i)
      tmi_pkg::ACT_CELL_INC: cell_new = cell_q + CELL_W'(1);
      tmi_pkg::ACT_CELL_DEC: cell_new = cell_q - CELL_W'(1);
      default: cell_new = {{(CELL_W-8){in_q.input_char[7]}}, in_q.input_char};
    endcase
  end

  always_comb begin
    len_d   = len_q;
    lp_d    = lp_q;
    pc_d    = pc_q;
    dp_d    = dp_q;
    halt_d  = halt_q;
    err_d   = err_q;
    scan_d  = scan_q;
    depth_d = depth_q;
    fwd_d   = fwd_q;
    rv_d    = rv_q;
    rc_d    = rc_q;
    ru_d    = ru_q;
    unique case (act_i)
      tmi_pkg::ACT_LATCH: begin
        rv_d = 1'b0;
        rc_d = '0;
        ru_d = 1'b0;
      end
      tmi_pkg::ACT_LOAD: begin
        lp_d = lp_next;
        if (in_q.last_byte) begin
          len_d  = lp_next;
          lp_d   = '0;
          pc_d   = '0;
          dp_d   = '0;
          halt_d = 1'b0;
          err_d  = tmi_pkg::ERR_NONE;
        end
      end
      tmi_pkg::ACT_DP_INC:   dp_d = dp_q + DP_W'(1);
      tmi_pkg::ACT_DP_DEC:   dp_d = dp_q - DP_W'(1);
      tmi_pkg::ACT_PUT_CHAR: begin
        rv_d = 1'b1;
        rc_d = cell_q[7:0];
      end
      tmi_pkg::ACT_GET_CHAR: ru_d = 1'b1;
      tmi_pkg::ACT_SCAN_FWD: begin
        scan_d  = pc_q;
        depth_d = PC_W'(1);
        fwd_d   = 1'b1;
      end
      tmi_pkg::ACT_SCAN_BWD: begin
        scan_d  = pc_q;
        depth_d = PC_W'(1);
        fwd_d   = 1'b0;
      end
      tmi_pkg::ACT_SCAN_STEP:  scan_d  = scan_nxt;
      tmi_pkg::ACT_SCAN_DEPTH: depth_d = depth_new;
      tmi_pkg::ACT_PC_MATCH:   pc_d    = scan_q + PC_W'(1);
      tmi_pkg::ACT_PC_INC:     pc_d    = pc_q + PC_W'(1);
      tmi_pkg::ACT_SET_HALT:   halt_d  = 1'b1;
      tmi_pkg::ACT_ERR_PTR: begin
        halt_d = 1'b1;
        err_d  = tmi_pkg::ERR_PTR;
      end
      tmi_pkg::ACT_ERR_BR: begin
        halt_d = 1'b1;
        err_d  = tmi_pkg::ERR_BRACKET;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      lp_q       <= '0;
      pc_q       <= '0;
      dp_q       <= '0;
      halt_q     <= 1'b0;
      err_q      <= tmi_pkg::ERR_NONE;
      scan_q     <= '0;
      depth_q    <= '0;
      fwd_q      <= 1'b0;
      rv_q       <= 1'b0;
      rc_q       <= '0;
      ru_q       <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      len_q   <= len_d;
      lp_q    <= lp_d;
      pc_q    <= pc_d;
      dp_q    <= dp_d;
      halt_q  <= halt_d;
      err_q   <= err_d;
      scan_q  <= scan_d;
      depth_q <= depth_d;
      fwd_q   <= fwd_d;
      rv_q    <= rv_d;
      rc_q    <= rc_d;
      ru_q    <= ru_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + DP_W'(1);
        if (clr_addr_q == DP_W'(tmi_pkg::TAPE_CELLS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_i == tmi_pkg::ACT_LATCH) begin
      in_q <= in_i;
    end
  end

  // program store: one write, one registered read
  assign prog_we    = (act_i == tmi_pkg::ACT_LOAD) && lp_room;
  assign prog_re    = (act_i == tmi_pkg::ACT_RD_OP) || (act_i == tmi_pkg::ACT_SCAN_STEP);
  assign prog_raddr = (act_i == tmi_pkg::ACT_SCAN_STEP) ? scan_nxt[PA_W-1:0]
                                                        : pc_q[PA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (prog_we) begin
      prog_mem[lp_q[PA_W-1:0]] <= in_q.program_byte;
    end
    if (prog_re) begin
      prog_rd_q <= prog_mem[prog_raddr];
    end
  end

  // tape: clear sweep after reset, then read-modify-write at dp
  assign tape_re    = (act_i == tmi_pkg::ACT_RD_OP);
  assign tape_we    = clr_busy_q || (act_i == tmi_pkg::ACT_CELL_INC) ||
                      (act_i == tmi_pkg::ACT_CELL_DEC) || (act_i == tmi_pkg::ACT_GET_CHAR);
  assign tape_waddr = clr_busy_q ? clr_addr_q : dp_q;
  assign tape_wdata = clr_busy_q ? '0 : cell_new;

  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_waddr] <= tape_wdata;
    end
    if (tape_re) begin
      cell_q <= tape_mem[dp_q];
    end
  end

  assign stat_o.clr_busy  = clr_busy_q;
  assign stat_o.halted    = halt_q;
  assign stat_o.pc_end    = (pc_q >= len_q);
  assign stat_o.dp_last   = (dp_q == DP_W'(tmi_pkg::TAPE_CELLS - 1));
  assign stat_o.dp_first  = (dp_q == '0);
  assign stat_o.cell_zero = (cell_q == '0);
  assign stat_o.scan_end  = fwd_q ? ((scan_q + PC_W'(1)) >= len_q) : (scan_q == '0);
  assign stat_o.no_match  = (depth_new != '0);
  assign stat_o.opcode    = prog_rd_q;

  assign res_o.out_valid  = rv_q;
  assign res_o.out_char   = rc_q;
  assign res_o.input_used = ru_q;
  assign res_o.halted     = halt_q;
  assign res_o.error_code = err_q;

endmodule

FILE: rtl/tape_machine_interpreter.sv
// tape_machine_interpreter: eight-instruction tape machine, microcoded.
// Instantiates tmi_seq and tmi_datapath; depends on tmi_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_i) takes one word per item:
//   command 0 appends program_byte to the program store (last_byte closes
//   the load and restarts pc, pointer, halt and error), command 1 runs one
//   instruction, with input_char used by the input instruction.
//   Output channel (out_valid_o / out_ready_i / out_o) returns one word per
//   item: output char, input-used flag, halted flag and error code.
// Sequence, accept to result valid: a load word is stored and returned;
//   a step on a halted machine returns without running; at program end it
//   halts; else the byte at pc is read and dispatched (a skipped byte only
//   advances pc), and a taken bracket scans the program byte by byte.
//   The control store runs one micro-step per cycle unless stalled, with one
//   registered read port each on the program store and on the tape.
// Throughput: one item at a time; the next word can be taken in the cycle
//   after the previous result is loaded into the output register.
// Reset: the tape is zeroed by a sweep over all TAPE_CELLS cells (one cell per
//   cycle); in_ready_o stays low until it completes.
// Receiver stall: the result waits in the output register; the next item
//   can still be accepted and runs up to its own result, then holds.
module tape_machine_interpreter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tmi_pkg::tmi_in_t           in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tmi_pkg::tmi_out_t          out_o
);

  tmi_pkg::act_e      act;
  tmi_pkg::tmi_stat_t stat;
  tmi_pkg::tmi_out_t  res;
  tmi_pkg::tmi_out_t  out_q;
  logic               out_valid_q;
  logic               out_busy;

  // Output slot is free when empty or being drained this cycle
  assign out_busy = out_valid_q && !out_ready_i;

  tmi_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_i.command),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .ready_o    (in_ready_o),
    .act_o      (act)
  );

  tmi_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .act_i  (act),
    .stat_o (stat),
    .res_o  (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (act == tmi_pkg::ACT_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act == tmi_pkg::ACT_EMIT) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  // An error always comes with the halt flag
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.error_code != tmi_pkg::ERR_NONE)) |-> out_o.halted)
    else $error("error reported without halt");

  // No item is taken while the tape clear sweep runs
  a_clr_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clr_busy |-> !in_ready_o)
    else $error("input accepted during tape clear");

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act == tmi_pkg::ACT_EMIT) |-> !out_busy)
    else $error("output register overwritten");

  // Char field is zero unless an output instruction ran
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.out_valid) |-> (out_o.out_char == 8'd0))
    else $error("out_char set without output instruction");
`endif

endmodule
